FILE: hdl/arm_subset_alu_execute_core_macros.svh
// ----------------------------------------------------------------------------
// arm_subset_alu_execute_core assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ARM_SUBSET_ALU_EXECUTE_CORE_MACROS_SVH
`define ARM_SUBSET_ALU_EXECUTE_CORE_MACROS_SVH

`ifndef SYNTH
`define ASAE_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asae assertion failed");
`define ASAE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asae assertion failed");
`else
`define ASAE_ASSERT_IMPL(name, clk, rst, ante, cons)
`define ASAE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/asae_pkg.sv
// ----------------------------------------------------------------------------
// asae_pkg
// shared types, codes and helpers of the arm subset execute core
// ----------------------------------------------------------------------------
package asae_pkg;

  localparam int XLEN       = 32;
  localparam int REG_ADDR_W = 4;
  localparam int NREGS      = 16;

  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_C = 1;
  localparam int FLAG_V = 0;

  localparam logic [3:0] MUL_MARK = 4'b1001;

  typedef logic [XLEN-1:0]       word_t;
  typedef logic [REG_ADDR_W-1:0] reg_addr_t;
  typedef logic [3:0]            flags_t;

  typedef enum logic [1:0] {
    CLASS_DP     = 2'd0,
    CLASS_MUL    = 2'd1,
    CLASS_MEM    = 2'd2,
    CLASS_BRANCH = 2'd3
  } class_t;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14
  } cond_t;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13
  } opcode_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  typedef struct packed {
    logic      en;
    reg_addr_t addr_m;
    reg_addr_t addr_s;
    reg_addr_t addr_n;
  } rd_req_t;

  typedef struct packed {
    word_t rm;
    word_t rs;
    word_t rn;
  } rd_data_t;

  typedef struct packed {
    logic      en;
    reg_addr_t addr;
    word_t     data;
  } wr_t;

  typedef struct packed {
    class_t    instr_class;
    logic      cond_passed;
    logic      reg_written;
    reg_addr_t dest_reg;
    word_t     result_value;
    flags_t    flags;
    logic      unsupported;
    logic      is_halt;
  } exec_t;

  function automatic logic is_mul_word(word_t w);
    return !w[27] && !w[26] && (w[25:22] == 4'b0000) && (w[7:4] == MUL_MARK);
  endfunction

endpackage

FILE: hdl/asae_if.sv
// ----------------------------------------------------------------------------
// asae stream interfaces
// valid/ready channels for instruction words and execute results
// ----------------------------------------------------------------------------
interface asae_instr_if;
  import asae_pkg::*;
  logic  valid;
  logic  ready;
  word_t instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface asae_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  instr_class;
  logic        cond_passed;
  logic        reg_written;
  logic [3:0]  dest_reg;
  logic [31:0] result_value;
  logic [3:0]  flags_out;
  logic        unsupported;
  logic        is_halt;
  modport source (
    output valid, output instr_class, output cond_passed, output reg_written,
    output dest_reg, output result_value, output flags_out, output unsupported,
    output is_halt, input ready
  );
  modport sink (
    input valid, input instr_class, input cond_passed, input reg_written,
    input dest_reg, input result_value, input flags_out, input unsupported,
    input is_halt, output ready
  );
endinterface

FILE: hdl/asae_regfile.sv
// ----------------------------------------------------------------------------
// asae_regfile
// 16 x 32 register file, two copies for three registered reads, one write,
// per-entry written bits and a bypass of the most recent write
// ----------------------------------------------------------------------------
module asae_regfile (
  input  logic              clk,
  input  logic              rst,
  input  asae_pkg::rd_req_t rd_req,
  input  asae_pkg::wr_t     wr,
  output asae_pkg::rd_data_t rd_data
);
  import asae_pkg::*;

  word_t            mem_a [NREGS];
  word_t            mem_b [NREGS];
  logic [NREGS-1:0] written;
  wr_t              last;
  reg_addr_t        addr_m_q;
  reg_addr_t        addr_s_q;
  reg_addr_t        addr_n_q;
  word_t            data_m_q;
  word_t            data_s_q;
  word_t            data_n_q;
  logic             vld_m_q;
  logic             vld_s_q;
  logic             vld_n_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.addr] <= wr.data;
      mem_b[wr.addr] <= wr.data;
    end
    if (rd_req.en) begin
      data_m_q <= mem_a[rd_req.addr_m];
      data_s_q <= mem_a[rd_req.addr_s];
      data_n_q <= mem_b[rd_req.addr_n];
      addr_m_q <= rd_req.addr_m;
      addr_s_q <= rd_req.addr_s;
      addr_n_q <= rd_req.addr_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      last    <= '0;
      vld_m_q <= 1'b0;
      vld_s_q <= 1'b0;
      vld_n_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
        last             <= wr;
      end
      if (rd_req.en) begin
        vld_m_q <= written[rd_req.addr_m];
        vld_s_q <= written[rd_req.addr_s];
        vld_n_q <= written[rd_req.addr_n];
      end
    end
  end

  // a write at the read edge is missed by the array, take it from last
  assign rd_data.rm = (last.en && last.addr == addr_m_q) ? last.data :
                      (vld_m_q ? data_m_q : '0);
  assign rd_data.rs = (last.en && last.addr == addr_s_q) ? last.data :
                      (vld_s_q ? data_s_q : '0);
  assign rd_data.rn = (last.en && last.addr == addr_n_q) ? last.data :
                      (vld_n_q ? data_n_q : '0);

endmodule

FILE: hdl/asae_alu.sv
// ----------------------------------------------------------------------------
// asae_alu
// condition check, decode, barrel shifter, data processing and multiply
// ----------------------------------------------------------------------------
module asae_alu (
  input  asae_pkg::word_t    instruction,
  input  asae_pkg::rd_data_t ops,
  input  asae_pkg::flags_t   flags,
  output asae_pkg::exec_t    exec
);
  import asae_pkg::*;

  logic        halt;
  class_t      cls;
  logic        cond_ok;
  logic        fn;
  logic        fz;
  logic        fv;
  logic [7:0]  sh_amt;
  logic [7:0]  lsr_amt;
  logic [4:0]  ror_amt;
  logic        by_reg;
  logic [32:0] lsl_ext;
  logic [32:0] lsr_ext;
  logic signed [32:0] asr_ext;
  word_t       ror_val;
  word_t       sh_res;
  logic        sh_c;
  logic [4:0]  imm_rot;
  word_t       imm_val;
  word_t       op2;
  logic        op2_c;
  word_t       rn;
  logic [32:0] sum33;
  logic [32:0] sub33;
  logic [32:0] rsb33;
  logic        dp_known;
  logic        dp_write;
  logic        dp_arith;
  word_t       dp_res;
  logic        dp_c;
  logic        dp_v;
  word_t       prod;
  word_t       mul_res;

  always_comb begin
    halt = (instruction == '0);
    priority if (instruction[27]) begin
      cls = CLASS_BRANCH;
    end else if (instruction[26]) begin
      cls = CLASS_MEM;
    end else if (is_mul_word(instruction)) begin
      cls = CLASS_MUL;
    end else begin
      cls = CLASS_DP;
    end
  end

  assign fn = flags[FLAG_N];
  assign fz = flags[FLAG_Z];
  assign fv = flags[FLAG_V];

  always_comb begin
    unique case (cond_t'(instruction[31:28]))
      COND_EQ: cond_ok = fz;
      COND_NE: cond_ok = !fz;
      COND_GE: cond_ok = (fn == fv);
      COND_LT: cond_ok = (fn != fv);
      COND_GT: cond_ok = !fz && (fn == fv);
      COND_LE: cond_ok = fz || (fn != fv);
      COND_AL: cond_ok = 1'b1;
      default: cond_ok = 1'b0;
    endcase
  end

  // barrel shifter on rm
  assign by_reg  = instruction[4];
  assign sh_amt  = by_reg ? ops.rs[7:0] : {3'b000, instruction[11:7]};
  assign lsr_amt = (sh_amt == 8'd0) ? 8'd32 : sh_amt;
  assign ror_amt = sh_amt[4:0];
  assign lsl_ext = {1'b0, ops.rm} << sh_amt;
  assign lsr_ext = {ops.rm, 1'b0} >> lsr_amt;
  assign asr_ext = $signed({ops.rm, 1'b0}) >>> lsr_amt;
  assign ror_val = (ops.rm >> ror_amt) | (ops.rm << (6'd32 - {1'b0, ror_amt}));

  always_comb begin
    sh_res = ops.rm;
    sh_c   = flags[FLAG_C];
    if (!(by_reg && sh_amt == 8'd0)) begin
      unique case (shift_t'(instruction[6:5]))
        SH_LSL: begin
          if (sh_amt != 8'd0) begin
            sh_res = lsl_ext[31:0];
            sh_c   = lsl_ext[32];
          end
        end
        SH_LSR: begin
          sh_res = lsr_ext[32:1];
          sh_c   = lsr_ext[0];
        end
        SH_ASR: begin
          sh_res = asr_ext[32:1];
          sh_c   = asr_ext[0];
        end
        SH_ROR: begin
          if (!by_reg && sh_amt == 8'd0) begin
            sh_res = {flags[FLAG_C], ops.rm[31:1]};
            sh_c   = ops.rm[0];
          end else if (ror_amt == 5'd0) begin
            sh_res = ops.rm;
            sh_c   = ops.rm[31];
          end else begin
            sh_res = ror_val;
            sh_c   = ror_val[31];
          end
        end
        default: begin
          sh_res = ops.rm;
          sh_c   = flags[FLAG_C];
        end
      endcase
    end
  end

  // rotated immediate
  assign imm_rot = {instruction[11:8], 1'b0};
  assign imm_val = ({24'd0, instruction[7:0]} >> imm_rot) |
                   ({24'd0, instruction[7:0]} << (6'd32 - {1'b0, imm_rot}));

  always_comb begin
    if (instruction[25]) begin
      op2   = imm_val;
      op2_c = (imm_rot != 5'd0) ? imm_val[31] : flags[FLAG_C];
    end else begin
      op2   = sh_res;
      op2_c = sh_c;
    end
  end

  assign rn    = ops.rn;
  assign sum33 = {1'b0, rn} + {1'b0, op2};
  assign sub33 = {1'b0, rn} - {1'b0, op2};
  assign rsb33 = {1'b0, op2} - {1'b0, rn};

  always_comb begin
    dp_known = 1'b1;
    dp_write = 1'b1;
    dp_arith = 1'b0;
    dp_res   = '0;
    dp_c     = op2_c;
    dp_v     = fv;
    unique case (opcode_t'(instruction[24:21]))
      OP_AND: dp_res = rn & op2;
      OP_EOR: dp_res = rn ^ op2;
      OP_TST: begin
        dp_res   = rn & op2;
        dp_write = 1'b0;
      end
      OP_TEQ: begin
        dp_res   = rn ^ op2;
        dp_write = 1'b0;
      end
      OP_ORR: dp_res = rn | op2;
      OP_MOV: dp_res = op2;
      OP_SUB, OP_CMP: begin
        dp_res   = sub33[31:0];
        dp_c     = !sub33[32];
        dp_v     = ((rn ^ op2) & (rn ^ sub33[31:0])) >> 31 != '0;
        dp_arith = 1'b1;
        dp_write = (opcode_t'(instruction[24:21]) == OP_SUB);
      end
      OP_RSB: begin
        dp_res   = rsb33[31:0];
        dp_c     = !rsb33[32];
        dp_v     = ((op2 ^ rn) & (op2 ^ rsb33[31:0])) >> 31 != '0;
        dp_arith = 1'b1;
      end
      OP_ADD: begin
        dp_res   = sum33[31:0];
        dp_c     = sum33[32];
        dp_v     = ((rn ^ sum33[31:0]) & (op2 ^ sum33[31:0])) >> 31 != '0;
        dp_arith = 1'b1;
      end
      default: dp_known = 1'b0;
    endcase
  end

  // multiply, accumulate from the third read port
  assign prod    = ops.rm * ops.rs;
  assign mul_res = prod + (instruction[21] ? ops.rn : '0);

  always_comb begin
    exec              = '0;
    exec.instr_class  = halt ? CLASS_DP : cls;
    exec.is_halt      = halt;
    exec.unsupported  = !halt && (cls == CLASS_MEM || cls == CLASS_BRANCH);
    exec.cond_passed  = !halt && cond_ok;
    exec.flags        = flags;
    if (exec.cond_passed && cls == CLASS_MUL) begin
      exec.reg_written  = 1'b1;
      exec.dest_reg     = instruction[19:16];
      exec.result_value = mul_res;
      if (instruction[20]) begin
        exec.flags[FLAG_N] = mul_res[31];
        exec.flags[FLAG_Z] = (mul_res == '0);
      end
    end else if (exec.cond_passed && cls == CLASS_DP && dp_known) begin
      exec.result_value = dp_res;
      if (dp_write) begin
        exec.reg_written = 1'b1;
        exec.dest_reg    = instruction[15:12];
      end
      if (instruction[20]) begin
        exec.flags[FLAG_N] = dp_res[31];
        exec.flags[FLAG_Z] = (dp_res == '0);
        exec.flags[FLAG_C] = dp_c;
        exec.flags[FLAG_V] = dp_arith ? dp_v : fv;
      end
    end
  end

endmodule

FILE: hdl/arm_subset_alu_execute_core.sv
// ----------------------------------------------------------------------------
// arm_subset_alu_execute_core
// arm subset execute stage: condition, shifter, alu, multiply, nzcv flags
// ----------------------------------------------------------------------------
// pipeline: the instruction is registered in s1_instr, the result in res_q
// throughput: one instruction per cycle unless result.ready stalls, set by
//   the single execute stage with register file write-back bypass and flag
//   feedback in the same cycle
// reset: synchronous, clears flags, register written bits (all read as zero)
//   and all handshake state; no clearing pass
`include "arm_subset_alu_execute_core_macros.svh"

module arm_subset_alu_execute_core (
  input logic           clk,
  input logic           rst,
  asae_instr_if.sink    instr,
  asae_result_if.source result
);
  import asae_pkg::*;

  logic     s1_valid;
  word_t    s1_instr;
  logic     s1_fire;
  logic     in_xfer;
  flags_t   flags;
  rd_req_t  rd_req;
  rd_data_t rd_data;
  wr_t      wr;
  exec_t    exec;
  logic     res_valid;
  exec_t    res_q;

  assign s1_fire     = s1_valid && (!res_valid || result.ready);
  assign instr.ready = !rst && (!s1_valid || s1_fire);
  assign in_xfer     = instr.valid && instr.ready;

  assign rd_req.en     = in_xfer;
  assign rd_req.addr_m = instr.instruction[3:0];
  assign rd_req.addr_s = instr.instruction[11:8];
  assign rd_req.addr_n = is_mul_word(instr.instruction) ? instr.instruction[15:12]
                                                        : instr.instruction[19:16];

  assign wr.en   = s1_fire && exec.reg_written;
  assign wr.addr = exec.dest_reg;
  assign wr.data = exec.result_value;

  asae_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_req  (rd_req),
    .wr      (wr),
    .rd_data (rd_data)
  );

  asae_alu u_alu (
    .instruction (s1_instr),
    .ops         (rd_data),
    .flags       (flags),
    .exec        (exec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        res_valid <= 1'b1;
        flags     <= exec.flags;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_instr <= instr.instruction;
    end
    if (s1_fire) begin
      res_q <= exec;
    end
  end

  assign result.valid        = res_valid;
  assign result.instr_class  = res_q.instr_class;
  assign result.cond_passed  = res_q.cond_passed;
  assign result.reg_written  = res_q.reg_written;
  assign result.dest_reg     = res_q.dest_reg;
  assign result.result_value = res_q.result_value;
  assign result.flags_out    = res_q.flags;
  assign result.unsupported  = res_q.unsupported;
  assign result.is_halt      = res_q.is_halt;

  `ASAE_ASSERT_IMPL(a_write_needs_exec, clk, rst, wr.en, exec.cond_passed && !exec.unsupported)
  `ASAE_ASSERT_NEXT(a_halt_keeps_flags, clk, rst, s1_fire && exec.is_halt, flags == $past(flags))
  `ASAE_ASSERT_NEXT(a_write_reported, clk, rst, wr.en, result.reg_written && result.dest_reg == $past(wr.addr))
  `ASAE_ASSERT_IMPL(a_no_write_no_dest, clk, rst, result.valid && !result.reg_written, result.dest_reg == '0)

endmodule

FILE: bench/arm_subset_alu_execute_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arm_subset_alu_execute_core_tb
// runs a directed table and then random instruction words through the core.
// typed rows are checked against their table entry, all others against an
// in-bench model of register file, nzcv flags, barrel shifter, alu and multiplier.
// ----------------------------------------------------------------------------
module arm_subset_alu_execute_core_tb;
  import asae_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 460;

  typedef struct packed {
    logic  typed;
    word_t word;
    exec_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  asae_instr_if  instr ();
  asae_result_if result ();

  arm_subset_alu_execute_core u_top (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr),
    .result (result)
  );

  always #5 clk = ~clk;

  word_t     gpr [NREGS];
  flags_t    nzcv;
  exec_t     exp_q [$];
  stim_row_t row_q [$];
  stim_row_t dir_tbl [$];
  int        errors = 0;
  int        cycle_cnt = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  opcode_t   dp_ops [10] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
                             OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};

  function automatic logic cond_ok(logic [3:0] c);
    logic n, z, v;
    n = nzcv[FLAG_N];
    z = nzcv[FLAG_Z];
    v = nzcv[FLAG_V];
    case (c)
      COND_EQ: return z;
      COND_NE: return !z;
      COND_GE: return n == v;
      COND_LT: return n != v;
      COND_GT: return !z && (n == v);
      COND_LE: return z || (n != v);
      COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic word_t barrel(word_t val, shift_t kind, logic [7:0] amt,
                                   logic by_reg, logic cin, output logic cout);
    int n;
    int r;
    logic [63:0] dbl;
    n = amt;
    cout = cin;
    if (by_reg && n == 0) return val;
    case (kind)
      SH_LSL: begin
        if (n == 0) return val;
        if (n < 32) begin
          cout = val[32-n];
          return val << n;
        end
        cout = (n == 32) ? val[0] : 1'b0;
        return '0;
      end
      SH_LSR: begin
        if (n == 0) n = 32;
        if (n < 32) begin
          cout = val[n-1];
          return val >> n;
        end
        cout = (n == 32) ? val[31] : 1'b0;
        return '0;
      end
      SH_ASR: begin
        if (n == 0) n = 32;
        if (n >= 32) begin
          cout = val[31];
          return {XLEN{val[31]}};
        end
        cout = val[n-1];
        return $signed(val) >>> n;
      end
      default: begin
        // immediate ror by zero is rrx
        if (!by_reg && n == 0) begin
          cout = val[0];
          return {cin, val[31:1]};
        end
        r = n % 32;
        if (r == 0) begin
          cout = val[31];
          return val;
        end
        cout = val[r-1];
        dbl = {val, val} >> r;
        return dbl[31:0];
      end
    endcase
  endfunction

  function automatic exec_t predict_exec(word_t w);
    exec_t e;
    class_t cls;
    logic pass, s, arith, wr, known, cin, sc, c, v;
    logic [3:0] opc;
    reg_addr_t rd;
    word_t rn, op2, r, prod;
    logic [4:0] rot;
    logic [7:0] amt;
    logic [63:0] dbl;
    e = '0;
    if (w[27]) cls = CLASS_BRANCH;
    else if (w[26]) cls = CLASS_MEM;
    else if (w[25:22] == 4'b0000 && w[7:4] == MUL_MARK) cls = CLASS_MUL;
    else cls = CLASS_DP;
    if (w == '0) begin
      e.instr_class = CLASS_DP;
      e.is_halt = 1'b1;
      e.flags = nzcv;
      return e;
    end
    e.instr_class = cls;
    e.unsupported = (cls == CLASS_MEM || cls == CLASS_BRANCH);
    pass = cond_ok(w[31:28]);
    e.cond_passed = pass;
    if (pass && cls == CLASS_MUL) begin
      rd = w[19:16];
      prod = gpr[w[3:0]] * gpr[w[11:8]];
      if (w[21]) prod = prod + gpr[w[15:12]];
      gpr[rd] = prod;
      e.reg_written = 1'b1;
      e.dest_reg = rd;
      e.result_value = prod;
      if (w[20]) begin
        nzcv[FLAG_N] = prod[31];
        nzcv[FLAG_Z] = (prod == '0);
      end
    end else if (pass && cls == CLASS_DP) begin
      opc = w[24:21];
      rn = gpr[w[19:16]];
      rd = w[15:12];
      s = w[20];
      cin = nzcv[FLAG_C];
      sc = cin;
      c = cin;
      v = nzcv[FLAG_V];
      arith = 1'b0;
      wr = 1'b1;
      known = 1'b1;
      r = '0;
      if (w[25]) begin
        rot = {w[11:8], 1'b0};
        dbl = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot;
        op2 = dbl[31:0];
        if (rot != 0) sc = op2[31];
      end else begin
        amt = w[4] ? gpr[w[11:8]][7:0] : {3'b000, w[11:7]};
        op2 = barrel(gpr[w[3:0]], shift_t'(w[6:5]), amt, w[4], cin, sc);
      end
      case (opc)
        OP_AND: r = rn & op2;
        OP_EOR: r = rn ^ op2;
        OP_TST: begin
          r = rn & op2;
          wr = 1'b0;
        end
        OP_TEQ: begin
          r = rn ^ op2;
          wr = 1'b0;
        end
        OP_ORR: r = rn | op2;
        OP_MOV: r = op2;
        OP_SUB, OP_CMP: begin
          r = rn - op2;
          c = (rn >= op2);
          v = (rn[31] ^ op2[31]) & (rn[31] ^ r[31]);
          arith = 1'b1;
          wr = (opc == OP_SUB);
        end
        OP_RSB: begin
          r = op2 - rn;
          c = (op2 >= rn);
          v = (op2[31] ^ rn[31]) & (op2[31] ^ r[31]);
          arith = 1'b1;
        end
        OP_ADD: begin
          r = rn + op2;
          c = (r < rn);
          v = (rn[31] ^ r[31]) & (op2[31] ^ r[31]);
          arith = 1'b1;
        end
        default: known = 1'b0;
      endcase
      if (known) begin
        e.result_value = r;
        if (wr) begin
          gpr[rd] = r;
          e.reg_written = 1'b1;
          e.dest_reg = rd;
        end
        if (s) begin
          if (!arith) c = sc;
          nzcv = {r[31], r == '0, c, v};
        end
      end
    end
    e.flags = nzcv;
    return e;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int pick;
    pick = $urandom_range(99);
    w = $urandom();
    if (pick == 0) return '0;
    if (pick < 8) return w;
    if ($urandom_range(99) < 55) w[31:28] = COND_AL;
    if (pick < 12) begin
      w[27] = 1'b1;
      return w;
    end
    if (pick < 16) begin
      w[27:26] = 2'b01;
      return w;
    end
    if (pick < 32) begin
      w[27:22] = 6'b000000;
      w[7:4] = MUL_MARK;
      return w;
    end
    w[27:26] = 2'b00;
    if ($urandom_range(9) != 0) w[24:21] = dp_ops[$urandom_range(9)];
    // small immediates keep shift counts and operands in interesting ranges
    if (pick < 45) begin
      w[25] = 1'b1;
      w[24:21] = OP_MOV;
      if ($urandom_range(2) != 0) w[11:8] = 4'h0;
    end
    return w;
  endfunction

  task automatic send(stim_row_t row);
    while ($urandom_range(99) < idle_pct) begin
      instr.valid <= 1'b0;
      @(posedge clk);
    end
    row_q.push_back(row);
    instr.valid <= 1'b1;
    instr.instruction <= row.word;
    do @(posedge clk); while (!instr.ready);
  endtask

  task automatic drain();
    instr.valid <= 1'b0;
    @(posedge clk);
    while (row_q.size() != 0 || exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : exec_monitor
    stim_row_t row;
    exec_t     want;
    if (!rst) begin
      if (instr.valid && instr.ready) begin
        row = row_q.pop_front();
        want = predict_exec(instr.instruction);
        if (row.typed) want = row.want;
        exp_q.push_back(want);
      end
      if (result.valid && result.ready) begin
        if (exp_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing pending", $time);
        end else begin
          want = exp_q.pop_front();
          check_field("instr_class", want.instr_class, result.instr_class);
          check_field("cond_passed", want.cond_passed, result.cond_passed);
          check_field("reg_written", want.reg_written, result.reg_written);
          check_field("dest_reg", want.dest_reg, result.dest_reg);
          check_field("result_value", want.result_value, result.result_value);
          check_field("flags_out", want.flags, result.flags_out);
          check_field("unsupported", want.unsupported, result.unsupported);
          check_field("is_halt", want.is_halt, result.is_halt);
        end
      end
    end
    result.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int phase;
    instr.valid = 1'b0;
    instr.instruction = '0;
    rst = 1'b1;
    for (int i = 0; i < NREGS; i++) gpr[i] = '0;
    nzcv = '0;

    // typed rows start from the reset state
    dir_tbl.push_back({1'b1, 32'h0000_0000,
                       {CLASS_DP, 1'b0, 1'b0, 4'd0, 32'h0, 4'h0, 1'b0, 1'b1}});
    dir_tbl.push_back({1'b1, 32'hE3A0_10FF,
                       {CLASS_DP, 1'b1, 1'b1, 4'd1, 32'h0000_00FF, 4'h0, 1'b0, 1'b0}});
    dir_tbl.push_back({1'b1, 32'hE3B0_21FF,
                       {CLASS_DP, 1'b1, 1'b1, 4'd2, 32'hC000_003F, 4'hA, 1'b0, 1'b0}});
    dir_tbl.push_back({1'b1, 32'hE3F0_3000,
                       {CLASS_DP, 1'b1, 1'b0, 4'd0, 32'h0, 4'hA, 1'b0, 1'b0}});
    // adds, subs to zero, rsbs, cmp with and without s, tst, teq
    dir_tbl.push_back({1'b0, 32'hE091_3002, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE051_4001, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE271_5000, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE151_0002, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE141_0002, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE311_0000, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE133_0001, exec_t'(0)});
    // lsr #32, asr #32, rrx, register shift by zero, ror by register with bit 7 set
    dir_tbl.push_back({1'b0, 32'hE032_6022, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE012_7042, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE191_8062, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE1B0_9A12, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE1B0_B1F2, exec_t'(0)});
    // r15 as plain register
    dir_tbl.push_back({1'b0, 32'hE3A0_F001, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE08F_C00F, exec_t'(0)});
    // muls and mla
    dir_tbl.push_back({1'b0, 32'hE010_0291, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hE02D_3291, exec_t'(0)});
    // each evaluated condition, then one that never holds
    dir_tbl.push_back({1'b0, 32'h03A0_E001, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'h13A0_E002, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hA3A0_E003, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hB3A0_E004, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hC3A0_E005, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hD3A0_E006, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'h23A0_E007, exec_t'(0)});
    // memory transfer and branch with a passing condition
    dir_tbl.push_back({1'b0, 32'hE591_2000, exec_t'(0)});
    dir_tbl.push_back({1'b0, 32'hEA00_0000, exec_t'(0)});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) send(dir_tbl[i]);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 53;
          stall_pct = 0;
        end
        2: begin
          drain();
          idle_pct = 0;
          stall_pct = 53;
        end
        default: begin
          idle_pct = 26;
          stall_pct = 26;
        end
      endcase
      repeat (PHASE_ITEMS) send({1'b0, rand_word(), exec_t'(0)});
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/asae_pkg.sv
hdl/asae_if.sv
hdl/asae_regfile.sv
hdl/asae_alu.sv
hdl/arm_subset_alu_execute_core.sv
bench/arm_subset_alu_execute_core_tb.sv
